// ----- sv/ps2s1_pkg.sv -----
// ----------------------------------------------------------------------------
// ps2s1_pkg
// Shared types, codes and key tables for the scan code set 1 decoder.
// ----------------------------------------------------------------------------
package ps2s1_pkg;

   localparam int CodeWidth   = 8;
   localparam int FlagWidth   = 10;
   localparam int KeyMapLen   = 192;
   localparam int ShiftMapLen = 54;

   // prefix and sequence bytes
   localparam logic [7:0] CODE_EXT       = 8'hE0;
   localparam logic [7:0] CODE_PAUSE     = 8'hE1;
   localparam logic [7:0] CODE_PAUSE_P1  = 8'h1D;
   localparam logic [7:0] CODE_PAUSE_R1  = 8'h9D;
   localparam logic [7:0] CODE_PAUSE_P2  = 8'h45;
   localparam logic [7:0] CODE_PAUSE_R2  = 8'hC5;
   localparam logic [7:0] CODE_PRT_P1    = 8'h2A;
   localparam logic [7:0] CODE_PRT_R1    = 8'hB7;
   localparam logic [7:0] CODE_PRT_P2    = 8'h37;
   localparam logic [7:0] CODE_PRT_R2    = 8'hAA;
   localparam logic [7:0] EXT_OFFSET     = 8'h50;
   localparam logic [7:0] LOW_MASK       = 8'h7F;

   // key table entries for modifier keys
   localparam logic [7:0] KEY_CAPS   = 8'h06;
   localparam logic [7:0] KEY_LSHIFT = 8'h03;
   localparam logic [7:0] KEY_RSHIFT = 8'h04;
   localparam logic [7:0] KEY_LCTRL  = 8'h02;
   localparam logic [7:0] KEY_RCTRL  = 8'h1E;
   localparam logic [7:0] KEY_LALT   = 8'h05;
   localparam logic [7:0] KEY_RALT   = 8'h1F;

   // flag word bit positions
   localparam int FLAG_PRESSED = 0;
   localparam int FLAG_CAPS    = 1;
   localparam int FLAG_LSHIFT  = 4;
   localparam int FLAG_RSHIFT  = 5;
   localparam int FLAG_LCTRL   = 6;
   localparam int FLAG_RCTRL   = 7;
   localparam int FLAG_LALT    = 8;
   localparam int FLAG_RALT    = 9;

   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_MASK    = 8'hDF;

   typedef struct packed {
      logic                 step;
      logic [CodeWidth-1:0] code;
   } step_type;

   typedef struct packed {
      logic                 emit;
      logic [CodeWidth-1:0] character;
      logic [FlagWidth-1:0] flags;
   } result_type;

   localparam logic [7:0] KEY_MAP [0:KeyMapLen-1] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h02, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h03, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h04, 8'h2A,
      8'h05, 8'h20, 8'h06, 8'h07, 8'h0E, 8'h0F, 8'h10, 8'h11,
      8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h37,
      8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
      8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h19,
      8'h1A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h1C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h1D, 8'h00, 8'h00, 8'h0A, 8'h1E, 8'h00, 8'h00,
      8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00,
      8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h2F, 8'h00, 8'h00,
      8'h1F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80,
      8'h81, 8'h82, 8'h00, 8'h83, 8'h00, 8'h84, 8'h00, 8'h85,
      8'h86, 8'h87, 8'h88, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D,
      8'h00, 8'h00, 8'h00, 8'h8E, 8'h00, 8'h8F, 8'h90, 8'h91,
      8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h00, 8'h00
   };

   localparam logic [7:0] SHIFT_MAP [0:ShiftMapLen-1] = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h7B, 8'h7D, 8'h0A, 8'h02, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3A,
      8'h22, 8'h7E, 8'h03, 8'h7C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h3C, 8'h3E, 8'h3F
   };

   // entries past the end of the key table read as zero
   function automatic logic [7:0] key_lookup(input logic [7:0] idx);
      logic [7:0] val;
      val = 8'h00;
      if (idx < 8'(KeyMapLen)) begin
         val = KEY_MAP[idx];
      end
      return val;
   endfunction

   function automatic logic [7:0] shift_lookup(input logic [7:0] idx);
      logic [7:0] val;
      val = 8'h00;
      if (idx < 8'(ShiftMapLen)) begin
         val = SHIFT_MAP[idx[5:0]];
      end
      return val;
   endfunction

endpackage

// ----- sv/ps2s1_seq.sv -----
// ----------------------------------------------------------------------------
// ps2s1_seq
// Prefix sequence machine: tracks E0/E1 prefixes, swallows Pause and
// Print Screen sequences and returns the key table entry for each byte.
// ----------------------------------------------------------------------------
module ps2s1_seq (
   input  logic                clock,
   input  logic                reset,
   input  ps2s1_pkg::step_type step_i,
   output logic [7:0]          entry
);

   typedef enum logic [3:0] {
      SQ_START  = 4'd0,
      SQ_EXT    = 4'd1,
      SQ_PAUSE  = 4'd2,
      SQ_PAUSEP = 4'd3,
      SQ_PAUSER = 4'd4,
      SQ_PRTP1  = 4'd5,
      SQ_PRTR1  = 4'd6,
      SQ_PRTP2  = 4'd7,
      SQ_PRTR2  = 4'd8,
      SQ_ERROR  = 4'd9
   } seq_state_type;

   seq_state_type state_ff, state_in;
   logic [7:0]    code;
   logic [7:0]    low_code;

   assign code     = step_i.code;
   assign low_code = code & ps2s1_pkg::LOW_MASK;

   always_comb begin
      state_in = state_ff;
      entry    = 8'h00;
      unique case (state_ff)
         SQ_EXT: begin
            if (code == ps2s1_pkg::CODE_PRT_P1) begin
               state_in = SQ_PRTP1;
            end else if (code == ps2s1_pkg::CODE_PRT_R1) begin
               state_in = SQ_PRTR1;
            end else begin
               state_in = SQ_START;
               entry    = ps2s1_pkg::key_lookup(low_code + ps2s1_pkg::EXT_OFFSET);
            end
         end
         SQ_PAUSE: begin
            if (code == ps2s1_pkg::CODE_PAUSE_P1) begin
               state_in = SQ_PAUSEP;
            end else if (code == ps2s1_pkg::CODE_PAUSE_R1) begin
               state_in = SQ_PAUSER;
            end else begin
               state_in = SQ_ERROR;
            end
         end
         SQ_PAUSEP: state_in = (code == ps2s1_pkg::CODE_PAUSE_P2) ? SQ_START : SQ_ERROR;
         SQ_PAUSER: state_in = (code == ps2s1_pkg::CODE_PAUSE_R2) ? SQ_START : SQ_ERROR;
         SQ_PRTP1:  state_in = (code == ps2s1_pkg::CODE_EXT) ? SQ_PRTP2 : SQ_ERROR;
         SQ_PRTR1:  state_in = (code == ps2s1_pkg::CODE_EXT) ? SQ_PRTR2 : SQ_ERROR;
         SQ_PRTP2:  state_in = (code == ps2s1_pkg::CODE_PRT_P2) ? SQ_START : SQ_ERROR;
         SQ_PRTR2:  state_in = (code == ps2s1_pkg::CODE_PRT_R2) ? SQ_START : SQ_ERROR;
         // drop one byte and resync
         SQ_ERROR:  state_in = SQ_START;
         default: begin
            if (code == ps2s1_pkg::CODE_EXT) begin
               state_in = SQ_EXT;
            end else if (code == ps2s1_pkg::CODE_PAUSE) begin
               state_in = SQ_PAUSE;
            end else begin
               state_in = SQ_START;
               entry    = ps2s1_pkg::key_lookup(low_code);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_START;
      end else if (step_i.step) begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/ps2s1_keymap.sv -----
// ----------------------------------------------------------------------------
// ps2s1_keymap
// Modifier flag register plus the Caps Lock and Shift translation rules.
// ----------------------------------------------------------------------------
module ps2s1_keymap (
   input  logic                  clock,
   input  logic                  reset,
   input  ps2s1_pkg::step_type   step_i,
   input  logic [7:0]            entry,
   output ps2s1_pkg::result_type result_o
);

   logic [ps2s1_pkg::FlagWidth-1:0] flags_ff, flags_in;
   logic                            release_code;
   logic                            caps;
   logic                            shift;
   logic [7:0]                      code;

   assign code         = step_i.code;
   assign release_code = code[7];

   always_comb begin
      flags_in = flags_ff;
      if (entry != 8'h00) begin
         flags_in[ps2s1_pkg::FLAG_PRESSED] = ~release_code;
         case (entry)
            ps2s1_pkg::KEY_CAPS: begin
               if (!release_code) begin
                  flags_in[ps2s1_pkg::FLAG_CAPS] = ~flags_ff[ps2s1_pkg::FLAG_CAPS];
               end
            end
            ps2s1_pkg::KEY_LSHIFT: flags_in[ps2s1_pkg::FLAG_LSHIFT] = ~release_code;
            ps2s1_pkg::KEY_RSHIFT: flags_in[ps2s1_pkg::FLAG_RSHIFT] = ~release_code;
            ps2s1_pkg::KEY_LCTRL:  flags_in[ps2s1_pkg::FLAG_LCTRL]  = ~release_code;
            ps2s1_pkg::KEY_RCTRL:  flags_in[ps2s1_pkg::FLAG_RCTRL]  = ~release_code;
            ps2s1_pkg::KEY_LALT:   flags_in[ps2s1_pkg::FLAG_LALT]   = ~release_code;
            ps2s1_pkg::KEY_RALT:   flags_in[ps2s1_pkg::FLAG_RALT]   = ~release_code;
            default: ;
         endcase
      end
   end

   assign caps  = flags_in[ps2s1_pkg::FLAG_CAPS];
   assign shift = flags_in[ps2s1_pkg::FLAG_LSHIFT] | flags_in[ps2s1_pkg::FLAG_RSHIFT];

   always_comb begin
      result_o.emit  = (entry != 8'h00) && flags_in[ps2s1_pkg::FLAG_PRESSED];
      result_o.flags = flags_in;
      if (entry >= ps2s1_pkg::CHAR_LOWER_A && entry <= ps2s1_pkg::CHAR_LOWER_Z
          && (caps != shift)) begin
         result_o.character = entry & ps2s1_pkg::CASE_MASK;
      end else if (code < 8'(ps2s1_pkg::ShiftMapLen) && shift) begin
         result_o.character = ps2s1_pkg::shift_lookup(code);
      end else begin
         result_o.character = entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (step_i.step) begin
         flags_ff <= flags_in;
      end
   end

endmodule

// ----- sv/ps2_set1_scancode_decoder.sv -----
// ----------------------------------------------------------------------------
// ps2_set1_scancode_decoder
// Scan code set 1 byte stream to character decoder with modifier tracking.
// ----------------------------------------------------------------------------
// Pipeline: an accepted byte passes the input register, then the result register;
//   a byte that yields no key press gives no result.
// Throughput: one byte per cycle unless a press waits on a stalled result;
//   decode between the registers: table lookup, flag update and shift rules.
// Reset: synchronous, active high; clears both registers' valid bits, the
//   sequence state (back to start) and the modifier flags.
module ps2_set1_scancode_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ps2s1_pkg::CodeWidth-1:0] req_scan_code,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ps2s1_pkg::CodeWidth-1:0] rsp_character,
   output logic [ps2s1_pkg::CodeWidth-1:0] rsp_key_code,
   output logic [ps2s1_pkg::FlagWidth-1:0] rsp_modifier_flags
);

   logic                            in_valid_ff, in_valid_in;
   logic [ps2s1_pkg::CodeWidth-1:0] in_code_ff;
   logic                            out_valid_ff, out_valid_in;
   logic [ps2s1_pkg::CodeWidth-1:0] out_character_ff;
   logic [ps2s1_pkg::CodeWidth-1:0] out_key_code_ff;
   logic [ps2s1_pkg::FlagWidth-1:0] out_flags_ff;

   ps2s1_pkg::step_type   step;
   ps2s1_pkg::result_type result;
   logic [7:0]            entry;
   logic                  accept;
   logic                  out_free;

   // the result slot is usable if empty or being drained this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step.step = in_valid_ff && (!result.emit || out_free);
   assign step.code = in_code_ff;
   assign req_stall = in_valid_ff && !step.step;
   assign accept    = req_valid && !req_stall;

   ps2s1_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .step_i (step),
      .entry  (entry)
   );

   ps2s1_keymap u_keymap (
      .clock    (clock),
      .reset    (reset),
      .step_i   (step),
      .entry    (entry),
      .result_o (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (step.step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step.step && result.emit) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_code_ff <= req_scan_code;
      end
      if (step.step && result.emit) begin
         out_character_ff <= result.character;
         out_key_code_ff  <= in_code_ff;
         out_flags_ff     <= result.flags;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_character      = out_character_ff;
   assign rsp_key_code       = out_key_code_ff;
   assign rsp_modifier_flags = out_flags_ff;

   // an emitted key is always a press with the unused flag bits clear
   a_rsp_is_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_modifier_flags[0] && !rsp_modifier_flags[2]
                     && !rsp_modifier_flags[3] && !rsp_key_code[7]))
      else $error("emitted item is not a clean key press");

   // a decoded press must land in the result register next cycle
   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      (step.step && result.emit) |=> (rsp_valid && rsp_key_code == $past(in_code_ff)))
      else $error("decoded press did not reach the result register");

   // back pressure on the input only while a byte waits on a full result slot
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall && result.emit))
      else $error("input stalled without a blocked result");

   // a held result must not be dropped or overwritten
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_character)
                                    && $stable(rsp_modifier_flags)))
      else $error("stalled result changed");

endmodule
